// ===== rtl/isrw_pkg.sv =====
`default_nettype none
package isrw_pkg;

    localparam int ISRW_DATA_WORDS   = 64;
    localparam int ISRW_CAL_WORDS    = 32;
    localparam int ISRW_WAVE_SAMPLES = 256;
    localparam int WAVE_BANKS        = 6;
    localparam int ISRW_DEPTH        = ISRW_DATA_WORDS + WAVE_BANKS * ISRW_WAVE_SAMPLES
                                       + ISRW_CAL_WORDS;
    localparam int WORD_W            = 16;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [2:0] OP_BUS_WRITE  = 3'd0;
    localparam logic [2:0] OP_READ_FIRST = 3'd1;
    localparam logic [2:0] OP_READ_NEXT  = 3'd2;
    localparam logic [2:0] OP_LOAD       = 3'd3;
    localparam logic [2:0] OP_TICK       = 3'd4;

    localparam logic [5:0] TYPE_DATA      = 6'd0;
    localparam logic [5:0] TYPE_CAL       = 6'd7;
    localparam logic [5:0] TYPE_CAL_WRITE = 6'd8;
    localparam logic [5:0] TYPE_DAC       = 6'd12;

    localparam logic [2:0] SEL_DATA = 3'd0;
    localparam logic [2:0] SEL_CAL  = 3'd7;

    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] store_value;
        logic [7:0]  store_index;
        logic [2:0]  store_select;
        logic [7:0]  bus_byte;
    } t_item;

    typedef struct packed {
        logic [4:0] pad;
        logic       timed_out;
        logic       cal_written;
        logic [7:0] dac_level;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/isrw_mem.sv =====
`default_nettype none
module isrw_mem
    import isrw_pkg::*;
#(
    parameter int DEPTH = ISRW_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/i2c_slave_register_window_core.sv =====
`default_nettype none
// Byte-level back end of an I2C slave register window. Each input transfer carries an opcode in
// tuser (bus write, first read, continued read, store load, millisecond tick) and its fields in
// tdata; every accepted item yields exactly one result transfer with the reply byte, its valid
// flag, the DAC level and the calibration-written and timeout pulses. The data table, the six
// waveform banks and the calibration table share one single-port-write synchronous memory: the
// read is issued on acceptance, and the word is picked and any write done when the item executes,
// which waits while an earlier result is unsent. One result may wait in the output register while
// the next item is accepted. After reset a clearing pass zeroes the memory, all DATA_WORDS + 6 *
// WAVE_SAMPLES + CAL_WORDS words (1632 with the defaults), one word a cycle, before the first item
// is taken; the timeout register may be written at any time the block is idle, including then.
module i2c_slave_register_window_core
    import isrw_pkg::*;
#(
    parameter int DATA_WORDS   = ISRW_DATA_WORDS,
    parameter int CAL_WORDS    = ISRW_CAL_WORDS,
    parameter int WAVE_SAMPLES = ISRW_WAVE_SAMPLES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // bus_byte[7:0], store_select[10:8], store_index[18:11], store_value[34:19], zero fill
    input  logic [39:0] s_axis_tdata,
    // opcode[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte[7:0], tx_valid[8], dac_level[16:9], cal_written[17], timed_out[18], zero fill
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int DEPTH    = DATA_WORDS + WAVE_BANKS * WAVE_SAMPLES + CAL_WORDS;
    localparam int AW       = $clog2(DEPTH);
    localparam int WaveBase = DATA_WORDS;
    localparam int CalBase  = DATA_WORDS + WAVE_BANKS * WAVE_SAMPLES;

    localparam logic [8:0]  DATA_LIM   = 9'(2 * DATA_WORDS);
    localparam logic [10:0] WAVE_LIM   = 11'(2 * WAVE_SAMPLES);
    localparam logic [10:0] CAL_LIM    = 11'(2 * CAL_WORDS);
    localparam logic [8:0]  DATA_COUNT = 9'(DATA_WORDS);
    localparam logic [8:0]  CAL_COUNT  = 9'(CAL_WORDS);
    localparam logic [8:0]  WAVE_COUNT = 9'(WAVE_SAMPLES);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    function automatic logic [AW-1:0] wave_addr(input logic [2:0] bank, input logic [7:0] word);
        return AW'(WaveBase + int'(bank) * WAVE_SAMPLES + int'(word));
    endfunction

    t_item   in_item;
    t_result n_result;
    t_result r_result;

    logic [1:0]    r_state;
    logic [AW-1:0] r_clr;
    logic          r_out_valid;
    logic [15:0]   r_timeout;

    logic [7:0]  r_rp,   n_rp;
    logic [9:0]  r_wp,   n_wp;
    logic [5:0]  r_type, n_type;
    logic [1:0]  r_seen, n_seen;
    logic [23:0] r_acc,  n_acc;
    logic [7:0]  r_dac,  n_dac;
    logic [15:0] r_ticks, n_ticks;

    logic [2:0]  r_op;
    logic [7:0]  r_byte;
    logic [2:0]  r_sel;
    logic [7:0]  r_idx;
    logic [15:0] r_val;
    logic [9:0]  r_ptr;

    logic          accept;
    logic          fire;
    logic [7:0]    rp_eff;
    logic [9:0]    wp_eff;
    logic [10:0]   wlim;
    logic [9:0]    rd_ptr;
    logic [AW-1:0] rd_addr;

    logic              ex_we;
    logic [AW-1:0]     ex_addr;
    logic [WORD_W-1:0] ex_data;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    logic [7:0]  pick;
    logic [10:0] ptr_inc;
    logic [10:0] ex_lim;
    logic [10:0] wp_inc;
    logic [23:0] acc_next;
    logic [1:0]  seen_next;
    logic [16:0] tick_next;

    assign in_item       = t_item'(s_axis_tdata);
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fire          = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 24'(r_result);

    // read address for the item about to be accepted
    always_comb begin
        rp_eff = ({1'b0, r_rp} >= DATA_LIM) ? 8'd0 : r_rp;
        wlim   = (r_type == TYPE_CAL) ? CAL_LIM : WAVE_LIM;
        wp_eff = ({1'b0, r_wp} >= wlim) ? 10'd0 : r_wp;
        if (r_type == TYPE_DATA) begin
            rd_ptr  = {2'b00, rp_eff};
            rd_addr = AW'(rp_eff[7:1]);
        end else if (r_type == TYPE_CAL) begin
            rd_ptr  = wp_eff;
            rd_addr = AW'(CalBase + int'(wp_eff[9:1]));
        end else begin
            rd_ptr  = wp_eff;
            rd_addr = wave_addr(r_type[2:0] - 3'd1, wp_eff[8:1]);
        end
    end

    always_comb begin
        pick      = r_ptr[0] ? mem_rdata[15:8] : mem_rdata[7:0];
        ptr_inc   = {1'b0, r_ptr} + 11'd1;
        ex_lim    = (r_type == TYPE_CAL) ? CAL_LIM : WAVE_LIM;
        wp_inc    = {1'b0, r_wp} + 11'd1;
        acc_next  = {r_acc[15:0], r_byte};
        seen_next = r_seen + 2'd1;
        tick_next = {1'b0, r_ticks} + 17'd1;

        n_rp    = r_rp;
        n_wp    = r_wp;
        n_type  = r_type;
        n_seen  = r_seen;
        n_acc   = r_acc;
        n_dac   = r_dac;
        n_ticks = r_ticks;
        ex_we   = 1'b0;
        ex_addr = AW'(r_idx);
        ex_data = r_val;

        n_result             = '0;

        case (r_op)
            OP_BUS_WRITE: begin
                n_ticks = '0;
                if (r_type == TYPE_CAL_WRITE) begin
                    n_acc  = acc_next;
                    n_seen = seen_next;
                    if (seen_next == 2'd3) begin
                        n_seen  = 2'd0;
                        n_type  = TYPE_DATA;
                        n_rp    = acc_next[23:16];
                        ex_addr = AW'(CalBase + int'(acc_next[23:16]));
                        ex_data = {acc_next[7:0], acc_next[15:8]};
                        if ({1'b0, acc_next[23:16]} < CAL_COUNT) begin
                            ex_we                = 1'b1;
                            n_result.cal_written = 1'b1;
                        end
                    end
                end else if (r_type == TYPE_DAC) begin
                    n_dac  = r_byte;
                    n_type = TYPE_DATA;
                end else begin
                    n_rp = r_byte;
                    if ({1'b0, r_byte} < DATA_COUNT) begin
                        n_type = TYPE_DATA;
                        n_rp   = {r_byte[6:0], 1'b0};
                    end else if (r_byte[7]) begin
                        n_type = r_byte[6:1];
                        if (!r_byte[0]) begin
                            n_wp = '0;
                        end else begin
                            n_wp = (wp_inc >= WAVE_LIM) ? 10'd0 : wp_inc[9:0];
                        end
                    end
                end
            end
            OP_READ_FIRST, OP_READ_NEXT: begin
                n_ticks = '0;
                if (r_type == TYPE_DATA) begin
                    n_result.tx_byte  = pick;
                    n_result.tx_valid = 1'b1;
                    n_rp = (ptr_inc >= {2'b00, DATA_LIM}) ? 8'd0 : ptr_inc[7:0];
                end else if (r_type <= TYPE_CAL) begin
                    n_result.tx_byte  = pick;
                    n_result.tx_valid = 1'b1;
                    if (r_op == OP_READ_FIRST) begin
                        n_wp = (ptr_inc >= ex_lim) ? 10'd0 : ptr_inc[9:0];
                    end else begin
                        n_wp = r_ptr;
                    end
                end
            end
            OP_LOAD: begin
                if (r_sel == SEL_DATA) begin
                    ex_we   = ({1'b0, r_idx} < DATA_COUNT);
                    ex_addr = AW'(r_idx);
                end else if (r_sel == SEL_CAL) begin
                    ex_we   = ({1'b0, r_idx} < CAL_COUNT);
                    ex_addr = AW'(CalBase + int'(r_idx));
                end else begin
                    ex_we   = ({1'b0, r_idx} < WAVE_COUNT);
                    ex_addr = wave_addr(r_sel - 3'd1, r_idx);
                end
            end
            OP_TICK: begin
                if (tick_next > {1'b0, r_timeout}) begin
                    n_ticks            = '0;
                    n_rp               = '0;
                    n_result.timed_out = 1'b1;
                end else begin
                    n_ticks = tick_next[15:0];
                end
            end
            default: begin
            end
        endcase

        n_result.dac_level = n_dac;
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else begin
            mem_we    = fire && ex_we;
            mem_waddr = ex_addr;
            mem_wdata = ex_data;
        end
    end

    isrw_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (accept),
        .i_raddr(rd_addr),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
            r_rp        <= '0;
            r_wp        <= '0;
            r_type      <= '0;
            r_seen      <= '0;
            r_acc       <= '0;
            r_dac       <= '0;
            r_ticks     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // hold a waiting result until the transfer completes
            if (fire) begin
                r_out_valid <= 1'b1;
                r_rp        <= n_rp;
                r_wp        <= n_wp;
                r_type      <= n_type;
                r_seen      <= n_seen;
                r_acc       <= n_acc;
                r_dac       <= n_dac;
                r_ticks     <= n_ticks;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= s_axis_tuser;
            r_byte <= in_item.bus_byte;
            r_sel  <= in_item.store_select;
            r_idx  <= in_item.store_index;
            r_val  <= in_item.store_value;
            r_ptr  <= rd_ptr;
        end
        if (fire) begin
            r_result <= n_result;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/isrw_checker.sv =====
`default_nettype none
module isrw_checker
    import isrw_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    t_result res;
    assign res = t_result'(m_axis_tdata);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res.tx_valid |-> res.tx_byte == 8'd0)
        else $error("reply byte set without valid flag");

    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(res.cal_written && res.timed_out))
        else $error("calibration and timeout pulses together");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken in consecutive cycles");

endmodule

bind i2c_slave_register_window_core isrw_checker u_isrw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
